>>> design/ewbs_pkg.sv
package ewbs_pkg;

  localparam int ID_W       = 32;
  localparam int MS_W       = 32;
  localparam int BUD_W      = 24;
  localparam int USED_W     = 32;
  localparam int BATT_W     = 7;
  localparam int PCT_W      = 7;
  localparam int MIN_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int PROD_W     = 18;
  localparam int TOTAL_W    = 24;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 40;

  localparam logic [9:0]        MS_PER_MIN_PCT = 10'd600;
  localparam logic [PCT_W-1:0]  PCT_FULL       = 7'd100;

  localparam logic [PCT_W-1:0] RST_BATT_THR = 7'd90;
  localparam logic [MIN_W-1:0] RST_WIN_MIN  = 8'd60;
  localparam logic [PCT_W-1:0] RST_RSV_PCT  = 7'd20;
  localparam logic [MIN_W-1:0] RST_MIN_WIN  = 8'd5;

  typedef enum logic [1:0] {
    OP_REGISTER,
    OP_EVALUATE,
    OP_PICK,
    OP_ACCOUNT
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BATT_THR,
    CFG_WIN_MIN,
    CFG_RSV_PCT,
    CFG_MIN_WIN
  } cfg_idx_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [BUD_W-1:0]  budget;
    logic [USED_W-1:0] used;
    logic              run;
  } entry_t;

  typedef struct packed {
    logic id;
    logic budget;
    logic used;
    logic run;
  } tbl_we_t;

endpackage

>>> design/ewbs_div.sv
module ewbs_div #(
  parameter int DW = 24,
  parameter int VW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [VW-1:0]    rem_q;
  logic [DW-1:0]    quo_q;
  logic [VW-1:0]    dvs_q;
  logic [VW:0]      step_sh;
  logic [VW:0]      step_df;
  logic             step_ge;

  assign step_sh = {rem_q, quo_q[DW-1]};
  assign step_df = step_sh - {1'b0, dvs_q};
  assign step_ge = step_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= step_ge ? step_df[VW-1:0] : step_sh[VW-1:0];
      quo_q <= {quo_q[DW-2:0], step_ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> design/ewbs_table.sv
module ewbs_table
  import ewbs_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk_i,
  input  tbl_we_t       we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          ren_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  logic [ID_W-1:0]   id_mem   [DEPTH];
  logic [BUD_W-1:0]  bud_mem  [DEPTH];
  logic [USED_W-1:0] used_mem [DEPTH];
  logic              run_mem  [DEPTH];
  entry_t            rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i.id) begin
      id_mem[waddr_i] <= wdata_i.id;
    end
    if (we_i.budget) begin
      bud_mem[waddr_i] <= wdata_i.budget;
    end
    if (we_i.used) begin
      used_mem[waddr_i] <= wdata_i.used;
    end
    if (we_i.run) begin
      run_mem[waddr_i] <= wdata_i.run;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ren_i) begin
      rdata_q.id     <= id_mem[raddr_i];
      rdata_q.budget <= bud_mem[raddr_i];
      rdata_q.used   <= used_mem[raddr_i];
      rdata_q.run    <= run_mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/energy_window_budget_scheduler_core.sv
// Energy-window budget scheduler for a table of batch tasks.
// Input items arrive on the s_axis channel: tuser carries the operation
// (register, evaluate, pick, account), tdata the task id, CPU time and power
// readings. Each item gives exactly one result item on m_axis: status,
// picked flag, picked id and the window flag after the operation.
// Configuration registers are written on the cfg channel, which is always
// ready; write them only while no item is in flight.
// The block takes one item at a time and drops s_axis_tready until the result
// is placed in the output register. Register, pick with the window closed and
// evaluate without a table sweep go straight to the result; an evaluate that
// closes sweeps the table; an evaluate that opens with budgets runs two multiply
// steps, then the 24-step divider that splits the window time, then the sweep;
// pick and account scan the task memory, one table entry read per cycle.
// s_axis_tready returns in the same cycle that the result appears on m_axis.
// A stalled receiver holds the result in the output register; the next item
// is still accepted and its result waits until that register frees up.
// Reset empties the table, closes the window and loads the default
// configuration; the task memory itself is not cleared.
module energy_window_budget_scheduler_core
  import ewbs_pkg::*;
#(
  parameter int MAX_TASKS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // task_id[31:0], cpu_ms[63:32], readings_valid[64], source_is_solar[65],
  // battery_level[72:66], zero fill above
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op[1:0]
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // status[0], picked_valid[1], picked_task_id[33:2], window_is_open[34],
  // zero fill above
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SWEEP,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                state_q, state_d;
  op_e                   op_q, op_d;
  logic [ID_W-1:0]       id_q, id_d;
  logic [MS_W-1:0]       ms_q, ms_d;
  logic                  win_q, win_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic                  rv_q, rv_d;
  logic [IW-1:0]         ridx_q, ridx_d;
  logic                  close_q, close_d;
  logic                  status_q, status_d;
  logic                  pv_q, pv_d;
  logic [ID_W-1:0]       pid_q, pid_d;
  logic [PROD_W-1:0]     prod_q, prod_d;
  logic [TOTAL_W-1:0]    total_q, total_d;
  logic                  mvalid_q, mvalid_d;
  logic [OUT_DATA_W-1:0] out_q, out_d;
  logic [PCT_W-1:0]      thr_q;
  logic [MIN_W-1:0]      wmin_q;
  logic [PCT_W-1:0]      rsv_q;
  logic [MIN_W-1:0]      mmin_q;

  logic                  in_acc;
  logic [ID_W-1:0]       in_id;
  logic [MS_W-1:0]       in_ms;
  logic                  in_valid;
  logic                  in_solar;
  logic [BATT_W-1:0]     in_batt;
  logic                  open_ok;
  logic [PCT_W-1:0]      rsv_sat;
  logic [PCT_W-1:0]      pct_left;

  tbl_we_t               tbl_we;
  logic [IW-1:0]         tbl_waddr;
  entry_t                tbl_wdata;
  logic                  tbl_ren;
  entry_t                tbl_rdata;

  logic                  div_start;
  logic                  div_done;
  logic [TOTAL_W-1:0]    div_quot;

  logic [USED_W:0]       acc_sum;
  logic [USED_W-1:0]     acc_used;
  logic                  match_pick;
  logic                  match_acct;
  logic                  hit;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_id    = s_axis_tdata[31:0];
  assign in_ms    = s_axis_tdata[63:32];
  assign in_valid = s_axis_tdata[64];
  assign in_solar = s_axis_tdata[65];
  assign in_batt  = s_axis_tdata[72:66];

  assign open_ok  = in_solar && (in_batt >= thr_q) && (cnt_q != '0);
  assign rsv_sat  = (rsv_q > PCT_FULL) ? PCT_FULL : rsv_q;
  assign pct_left = PCT_FULL - rsv_sat;

  assign acc_sum    = {1'b0, tbl_rdata.used} + {1'b0, ms_q};
  assign acc_used   = acc_sum[USED_W] ? '1 : acc_sum[USED_W-1:0];
  assign match_pick = tbl_rdata.run &&
                      ({{(USED_W-BUD_W){1'b0}}, tbl_rdata.budget} > tbl_rdata.used);
  assign match_acct = tbl_rdata.id == id_q;
  assign hit        = rv_q && ((op_q == OP_PICK) ? match_pick : match_acct);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = out_q;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    id_d      = id_q;
    ms_d      = ms_q;
    win_d     = win_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    rv_d      = rv_q;
    ridx_d    = ridx_q;
    close_d   = close_q;
    status_d  = status_q;
    pv_d      = pv_q;
    pid_d     = pid_q;
    prod_d    = prod_q;
    total_d   = total_q;
    out_d     = out_q;
    mvalid_d  = mvalid_q && !m_axis_tready;
    tbl_we    = '0;
    tbl_waddr = idx_q[IW-1:0];
    tbl_wdata = '0;
    tbl_ren   = 1'b0;
    div_start = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d     = op_e'(s_axis_tuser);
          id_d     = in_id;
          ms_d     = in_ms;
          status_d = 1'b0;
          pv_d     = 1'b0;
          pid_d    = '0;
          idx_d    = '0;
          rv_d     = 1'b0;
          state_d  = ST_DONE;
          case (op_e'(s_axis_tuser))
            OP_REGISTER: begin
              if (cnt_q >= CW'(MAX_TASKS)) begin
                status_d = 1'b1;
              end else begin
                tbl_we       = '1;
                tbl_waddr    = cnt_q[IW-1:0];
                tbl_wdata.id = in_id;
                cnt_d        = cnt_q + 1'b1;
              end
            end
            OP_EVALUATE: begin
              if (in_valid) begin
                if (open_ok && !win_q) begin
                  win_d = 1'b1;
                  if (wmin_q >= mmin_q) begin
                    state_d = ST_MUL1;
                  end
                end else if (!open_ok && win_q) begin
                  win_d   = 1'b0;
                  close_d = 1'b1;
                  state_d = ST_SWEEP;
                end
              end
            end
            OP_PICK: begin
              if (win_q) begin
                state_d = ST_SCAN;
              end
            end
            OP_ACCOUNT: begin
              state_d = ST_SCAN;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_MUL1: begin
        prod_d  = PROD_W'(wmin_q) * PROD_W'(MS_PER_MIN_PCT);
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        total_d = TOTAL_W'(prod_q) * TOTAL_W'(pct_left);
        state_d = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          close_d = 1'b0;
          idx_d   = '0;
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (idx_q < cnt_q) begin
          tbl_we.run       = 1'b1;
          tbl_we.budget    = !close_q;
          tbl_we.used      = !close_q;
          tbl_wdata.run    = !close_q;
          tbl_wdata.budget = div_quot;
          idx_d            = idx_q + 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          if (op_q == OP_PICK) begin
            pv_d  = 1'b1;
            pid_d = tbl_rdata.id;
          end else begin
            tbl_waddr      = ridx_q;
            tbl_we.used    = 1'b1;
            tbl_wdata.used = acc_used;
            if (acc_used >= {{(USED_W-BUD_W){1'b0}}, tbl_rdata.budget}) begin
              tbl_we.run    = 1'b1;
              tbl_wdata.run = 1'b0;
            end
          end
          state_d = ST_DONE;
        end else if (idx_q < cnt_q) begin
          tbl_ren = 1'b1;
          ridx_d  = idx_q[IW-1:0];
          idx_d   = idx_q + 1'b1;
          rv_d    = 1'b1;
        end else begin
          rv_d = 1'b0;
          if (!rv_q) begin
            if (op_q == OP_PICK) begin
              win_d = 1'b0;
            end
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!mvalid_q || m_axis_tready) begin
          out_d    = {{(OUT_DATA_W-35){1'b0}}, win_q, pid_q, pv_q, status_q};
          mvalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      op_q     <= OP_REGISTER;
      win_q    <= 1'b0;
      cnt_q    <= '0;
      idx_q    <= '0;
      rv_q     <= 1'b0;
      close_q  <= 1'b0;
      mvalid_q <= 1'b0;
      thr_q    <= RST_BATT_THR;
      wmin_q   <= RST_WIN_MIN;
      rsv_q    <= RST_RSV_PCT;
      mmin_q   <= RST_MIN_WIN;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      win_q    <= win_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      rv_q     <= rv_d;
      close_q  <= close_d;
      mvalid_q <= mvalid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_BATT_THR: thr_q  <= cfg_data_i[PCT_W-1:0];
          CFG_WIN_MIN:  wmin_q <= cfg_data_i[MIN_W-1:0];
          CFG_RSV_PCT:  rsv_q  <= cfg_data_i[PCT_W-1:0];
          CFG_MIN_WIN:  mmin_q <= cfg_data_i[MIN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    id_q     <= id_d;
    ms_q     <= ms_d;
    ridx_q   <= ridx_d;
    status_q <= status_d;
    pv_q     <= pv_d;
    pid_q    <= pid_d;
    prod_q   <= prod_d;
    total_q  <= total_d;
    out_q    <= out_d;
  end

  ewbs_div #(
    .DW (TOTAL_W),
    .VW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (total_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  ewbs_table #(
    .DEPTH (MAX_TASKS),
    .AW    (IW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .ren_i   (tbl_ren),
    .raddr_i (idx_q[IW-1:0]),
    .rdata_o (tbl_rdata)
  );

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_TASKS))
    else $error("task count above table depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("task count moved by other than one");

  a_win_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(win_q) |-> ($past(in_acc) && ($past(s_axis_tuser) == OP_EVALUATE)))
    else $error("window opened outside an evaluate item");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_WAIT))
    else $error("divider finished outside its wait state");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import ewbs_pkg::*;

  localparam int TASK_SLOTS    = 32;
  localparam int MS_PER_MINUTE = 60000;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 400;
  localparam int END_SETTLE    = 64;

  typedef struct {
    op_e               op;
    logic [ID_W-1:0]   task_id;
    logic [MS_W-1:0]   cpu_ms;
    logic              readings_valid;
    logic              solar;
    logic [BATT_W-1:0] battery;
  } request_t;

  typedef struct {
    logic            status;
    logic            picked_valid;
    logic [ID_W-1:0] picked_id;
    logic            window_open;
  } outcome_t;

  class budget_scoreboard;
    logic [ID_W-1:0]   ids     [TASK_SLOTS];
    logic [BUD_W-1:0]  budgets [TASK_SLOTS];
    logic [USED_W-1:0] used    [TASK_SLOTS];
    bit                running [TASK_SLOTS];
    int unsigned       count = 0;
    bit                win_open = 1'b0;
    logic [PCT_W-1:0]  thr     = RST_BATT_THR;
    logic [MIN_W-1:0]  win_min = RST_WIN_MIN;
    logic [PCT_W-1:0]  rsv     = RST_RSV_PCT;
    logic [MIN_W-1:0]  min_win = RST_MIN_WIN;
    outcome_t          expected_outcomes [$];
    int unsigned       mismatches = 0;
    int unsigned       checked = 0;
    int unsigned       picks_found = 0;
    int unsigned       budget_grants = 0;
    int unsigned       full_rejects = 0;

    function int pending();
      return expected_outcomes.size();
    endfunction

    function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (cfg_idx_e'(idx))
        CFG_BATT_THR: thr     = data[PCT_W-1:0];
        CFG_WIN_MIN:  win_min = data;
        CFG_RSV_PCT:  rsv     = data[PCT_W-1:0];
        CFG_MIN_WIN:  min_win = data;
        default: ;
      endcase
    endfunction

    function logic [ID_W-1:0] next_pick_id();
      for (int i = 0; i < count; i++) begin
        if (running[i] && used[i] < budgets[i]) return ids[i];
      end
      return (count > 0) ? ids[0] : '0;
    endfunction

    function outcome_t predict_outcome(request_t rq);
      outcome_t          res;
      bit                open_ok;
      int unsigned       reserve;
      longint unsigned   total;
      logic [BUD_W-1:0]  share;
      logic [USED_W:0]   sum;
      res.status       = 1'b0;
      res.picked_valid = 1'b0;
      res.picked_id    = '0;
      case (rq.op)
        OP_REGISTER: begin
          if (count >= TASK_SLOTS) begin
            res.status = 1'b1;
            full_rejects++;
          end else begin
            ids[count]     = rq.task_id;
            budgets[count] = '0;
            used[count]    = '0;
            running[count] = 1'b0;
            count++;
          end
        end
        OP_EVALUATE: begin
          if (rq.readings_valid) begin
            open_ok = rq.solar && (rq.battery >= thr) && (count > 0);
            if (open_ok && !win_open) begin
              win_open = 1'b1;
              if (win_min >= min_win) begin
                reserve = (rsv > PCT_FULL) ? 100 : rsv;
                total = longint'(win_min) * MS_PER_MINUTE * longint'(100 - reserve) / 100;
                share = BUD_W'(total / count);
                for (int i = 0; i < count; i++) begin
                  budgets[i] = share;
                  used[i]    = '0;
                  running[i] = 1'b1;
                end
                budget_grants++;
              end
            end else if (!open_ok && win_open) begin
              win_open = 1'b0;
              for (int i = 0; i < count; i++) running[i] = 1'b0;
            end
          end
        end
        OP_PICK: begin
          if (win_open) begin
            for (int i = 0; i < count; i++) begin
              if (running[i] && used[i] < budgets[i]) begin
                res.picked_valid = 1'b1;
                res.picked_id    = ids[i];
                break;
              end
            end
            if (res.picked_valid) picks_found++;
            else win_open = 1'b0;
          end
        end
        default: begin
          for (int i = 0; i < count; i++) begin
            if (ids[i] == rq.task_id) begin
              sum = {1'b0, used[i]} + {1'b0, rq.cpu_ms};
              used[i] = sum[USED_W] ? '1 : sum[USED_W-1:0];
              if (used[i] >= budgets[i]) running[i] = 1'b0;
              break;
            end
          end
        end
      endcase
      res.window_open = win_open;
      return res;
    endfunction

    function void note_item(logic [1:0] user, logic [IN_DATA_W-1:0] data);
      request_t rq;
      rq.op             = op_e'(user);
      rq.task_id        = data[31:0];
      rq.cpu_ms         = data[63:32];
      rq.readings_valid = data[64];
      rq.solar          = data[65];
      rq.battery        = data[72:66];
      expected_outcomes.push_back(predict_outcome(rq));
    endfunction

    task report_mismatch(string msg);
      $display("ERROR %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_outcome(logic [OUT_DATA_W-1:0] data);
      outcome_t want;
      checked++;
      if (expected_outcomes.size() == 0) begin
        report_mismatch($sformatf("result %h with no item pending", data));
        return;
      end
      want = expected_outcomes.pop_front();
      if (data[0] !== want.status)
        report_mismatch($sformatf("status got %b want %b", data[0], want.status));
      if (data[1] !== want.picked_valid)
        report_mismatch($sformatf("picked_valid got %b want %b", data[1], want.picked_valid));
      if (data[33:2] !== want.picked_id)
        report_mismatch($sformatf("picked_task_id got %h want %h", data[33:2], want.picked_id));
      if (data[34] !== want.window_open)
        report_mismatch($sformatf("window_is_open got %b want %b", data[34], want.window_open));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  wire                   s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  wire                   m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  wire  [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  wire                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  budget_scoreboard sb = new;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent = 0;
  logic [ID_W-1:0] known_ids [$];

  energy_window_budget_scheduler_core #(.MAX_TASKS(TASK_SLOTS)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_outcome(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tuser, s_axis_tdata);
      if (cfg_valid_i && cfg_ready_o) sb.apply_config(cfg_index_i, cfg_data_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic request_t make_request(op_e op, logic [ID_W-1:0] id,
                                            logic [MS_W-1:0] ms, logic rv, logic solar,
                                            logic [BATT_W-1:0] batt);
    request_t rq;
    rq.op             = op;
    rq.task_id        = id;
    rq.cpu_ms         = ms;
    rq.readings_valid = rv;
    rq.solar          = solar;
    rq.battery        = batt;
    return rq;
  endfunction

  function automatic logic [MS_W-1:0] random_ms();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom();
      4, 5, 6: return $urandom_range(3_000_000, 0);
      default: return $urandom_range(150_000, 0);
    endcase
  endfunction

  function automatic logic [ID_W-1:0] random_id();
    if (known_ids.size() > 0 && $urandom_range(3) != 0)
      return known_ids[$urandom_range(known_ids.size() - 1)];
    return $urandom();
  endfunction

  function automatic logic [ID_W-1:0] register_id();
    if (known_ids.size() >= 28 && $urandom_range(3) == 0)
      return known_ids[$urandom_range(known_ids.size() - 1)];
    return $urandom();
  endfunction

  function automatic logic [BATT_W-1:0] open_battery();
    if (sb.thr > PCT_FULL) return BATT_W'($urandom_range(100));
    return BATT_W'($urandom_range(100, sb.thr));
  endfunction

  function automatic logic [BATT_W-1:0] close_battery();
    if (sb.thr == 0) return BATT_W'($urandom_range(100));
    return BATT_W'($urandom_range((sb.thr > PCT_FULL) ? 100 : sb.thr - 1, 0));
  endfunction

  function automatic request_t noise_request();
    return make_request(op_e'($urandom_range(3)), random_id(), random_ms(),
                        1'($urandom_range(1)), 1'($urandom_range(1)),
                        BATT_W'($urandom_range(100)));
  endfunction

  task automatic send_request(request_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rq.op;
    s_axis_tdata  <= {7'd0, rq.battery, rq.solar, rq.readings_valid, rq.cpu_ms, rq.task_id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    if (rq.op == OP_REGISTER && known_ids.size() < TASK_SLOTS) known_ids.push_back(rq.task_id);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic configure(logic [7:0] thr, logic [7:0] win, logic [7:0] rsv,
                           logic [7:0] minw);
    write_cfg(CFG_BATT_THR, thr);
    write_cfg(CFG_WIN_MIN, win);
    write_cfg(CFG_RSV_PCT, rsv);
    write_cfg(CFG_MIN_WIN, minw);
    cfg_valid_i <= 1'b0;
  endtask

  // open a window, then alternate pick and account, sometimes close it again
  task automatic run_session();
    int unsigned pairs;
    pairs = $urandom_range(20, 2);
    repeat ($urandom_range(2)) begin
      send_request(make_request(OP_REGISTER, register_id(), $urandom(),
                                1'($urandom_range(1)), 1'($urandom_range(1)),
                                BATT_W'($urandom_range(100))));
    end
    send_request(make_request(OP_EVALUATE, $urandom(), $urandom(), 1'b1, 1'b1,
                              open_battery()));
    repeat (pairs) begin
      send_request(make_request(OP_PICK, $urandom(), $urandom(), 1'($urandom_range(1)),
                                1'($urandom_range(1)), BATT_W'($urandom_range(100))));
      send_request(make_request(OP_ACCOUNT,
                                ($urandom_range(4) != 0) ? sb.next_pick_id() : random_id(),
                                random_ms(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                                BATT_W'($urandom_range(100))));
    end
    if ($urandom_range(1)) begin
      send_request(make_request(OP_EVALUATE, $urandom(), $urandom(), 1'b1,
                                1'($urandom_range(1)), close_battery()));
    end
  endtask

  task automatic run_phase(logic [7:0] thr, logic [7:0] win, logic [7:0] rsv,
                           logic [7:0] minw, int unsigned idle_pct, int unsigned stall_pct,
                           int unsigned target, bit hold);
    drain();
    configure(thr, win, rsv, minw);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (hold) hold_request = 1'b1;
    while (items_sent < target) begin
      if ($urandom_range(99) < 30) send_request(noise_request());
      else run_session();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, default configuration
    send_request(make_request(OP_PICK, '0, '0, 1'b0, 1'b0, 7'd0));
    send_request(make_request(OP_EVALUATE, '0, '0, 1'b1, 1'b1, 7'd100));
    send_request(make_request(OP_ACCOUNT, 32'd7, 32'd1, 1'b0, 1'b0, 7'd0));
    send_request(make_request(OP_REGISTER, '0, '0, 1'b0, 1'b0, 7'd0));
    send_request(make_request(OP_REGISTER, '1, '1, 1'b1, 1'b1, 7'd127));
    send_request(make_request(OP_EVALUATE, '0, '0, 1'b0, 1'b1, 7'd100));
    send_request(make_request(OP_EVALUATE, '0, '0, 1'b1, 1'b0, 7'd100));
    send_request(make_request(OP_EVALUATE, '0, '0, 1'b1, 1'b1, 7'd89));
    send_request(make_request(OP_EVALUATE, '0, '0, 1'b1, 1'b1, 7'd90));
    send_request(make_request(OP_EVALUATE, '0, '0, 1'b1, 1'b1, 7'd100));
    send_request(make_request(OP_PICK, '0, '0, 1'b0, 1'b0, 7'd0));
    send_request(make_request(OP_ACCOUNT, '0, 32'd1_439_999, 1'b0, 1'b0, 7'd0));
    send_request(make_request(OP_PICK, '0, '0, 1'b0, 1'b0, 7'd0));
    send_request(make_request(OP_ACCOUNT, '0, 32'd1, 1'b0, 1'b0, 7'd0));
    send_request(make_request(OP_PICK, '0, '0, 1'b0, 1'b0, 7'd0));
    send_request(make_request(OP_ACCOUNT, '1, '1, 1'b0, 1'b0, 7'd0));
    send_request(make_request(OP_ACCOUNT, '1, 32'd2, 1'b0, 1'b0, 7'd0));
    send_request(make_request(OP_ACCOUNT, 32'h1234_5678, 32'd5, 1'b0, 1'b0, 7'd0));
    send_request(make_request(OP_PICK, '0, '0, 1'b0, 1'b0, 7'd0));
    send_request(make_request(OP_PICK, '0, '0, 1'b0, 1'b0, 7'd0));
    send_request(make_request(OP_REGISTER, 32'h5A5A_A5A5, '0, 1'b0, 1'b0, 7'd0));
    send_request(make_request(OP_EVALUATE, '0, '0, 1'b1, 1'b1, 7'd100));
    send_request(make_request(OP_ACCOUNT, 32'h5A5A_A5A5, 32'd960_000, 1'b0, 1'b0, 7'd0));
    send_request(make_request(OP_PICK, '0, '0, 1'b0, 1'b0, 7'd0));
    send_request(make_request(OP_EVALUATE, '0, '0, 1'b1, 1'b1, 7'd0));

    run_phase(8'd90, 8'd60, 8'd20, 8'd5, 0, 0, 220, 1'b0);
    run_phase(8'd0, 8'd255, 8'd0, 8'd255, 51, 0, 440, 1'b0);
    run_phase(8'd100, 8'd0, 8'hE5, 8'd0, 0, 51, 580, 1'b0);
    run_phase(8'hFF, 8'd255, 8'd127, 8'd0, 9, 9, 640, 1'b0);
    run_phase(8'd45, 8'd3, 8'd50, 8'd10, 9, 9, 820, 1'b0);
    run_phase(8'h80, 8'd120, 8'd10, 8'd120, 0, 0, 1000, 1'b1);
    run_phase(8'd70, 8'd1, 8'd99, 8'd1, 51, 0, 1200, 1'b0);
    run_phase(8'd90, 8'd60, 8'd100, 8'd0, 0, 51, 1350, 1'b0);
    run_phase(8'd30, 8'd200, 8'd5, 8'd0, 0, 0, 1550, 1'b0);

    drain();
    repeat (END_SETTLE) @(posedge clk_i);
    $display("covered %0d items over %0d tasks: %0d results checked, %0d picks found,",
             items_sent, sb.count, sb.checked, sb.picks_found);
    $display("  %0d windows opened with budgets, %0d registers refused on a full table",
             sb.budget_grants, sb.full_rejects);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
design/ewbs_pkg.sv
design/ewbs_div.sv
design/ewbs_table.sv
design/energy_window_budget_scheduler_core.sv
verif/tb.sv
